[hdl/ttc_pkg.sv]
// Shared types and constants for the text terminal cursor engine.
`default_nettype none

package ttc_pkg;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int GLYPH_W = 7;
  localparam int ARG_W = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_J  = 8'h4A;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_PLACE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_PRINT,
    OP_TAB,
    OP_NEWLINE,
    OP_CR,
    OP_BS,
    OP_FF,
    OP_UP,
    OP_DOWN,
    OP_RIGHT,
    OP_LEFT,
    OP_HOME,
    OP_CLEAR
  } op_code_t;

  typedef struct packed {
    op_code_t         code;
    logic [ARG_W-1:0] arg1;
    logic [ARG_W-1:0] arg2;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_SCROLL,
    BK_PLACE,
    BK_TAIL,
    BK_CLEAR
  } back_state_t;

endpackage

`default_nettype wire

[hdl/ttc_channels.sv]
// Valid/ready channel interfaces for character bytes and screen commands.
`default_nettype none

interface ttc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface ttc_cmd_if import ttc_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [GLYPH_W-1:0] glyph;
  logic               last;

  modport source (output valid, output command, output row, output column,
                  output glyph, output last, input ready);
  modport sink (input valid, input command, input row, input column,
                input glyph, input last, output ready);
endinterface

`default_nettype wire

[hdl/ttc_front.sv]
// Byte classifier: escape sequence parsing and translation into cursor operations.
`default_nettype none

module ttc_front import ttc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ttc_byte_if.sink   byte_ch,
  output op_t        push_op,
  output logic       push_valid,
  input  wire logic  push_ready
);

  logic             escape_active, escape_active_next;
  logic [ARG_W-1:0] first_arg, first_arg_next;
  logic [ARG_W-1:0] second_arg, second_arg_next;
  logic             semicolon_seen, semicolon_seen_next;

  logic             take;
  logic             has_op;
  logic [7:0]       c;
  logic             is_digit;
  logic             is_letter;
  logic [3:0]       digit;

  function automatic logic [ARG_W-1:0] add_digit(input logic [ARG_W-1:0] a,
                                                 input logic [3:0] d);
    logic [11:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {8'b0, d};
    return (t > 12'd255) ? 8'hFF : t[7:0];
  endfunction

  assign c = byte_ch.char_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                     ((c >= CH_LO_A) && (c <= CH_LO_Z));
  assign digit = 4'(c - CH_ZERO);

  // a byte is taken whenever the queue has room, even one that yields nothing
  assign byte_ch.ready = push_ready;
  assign take = byte_ch.valid && push_ready;
  assign push_valid = take && has_op;

  always_comb begin
    escape_active_next = escape_active;
    first_arg_next = first_arg;
    second_arg_next = second_arg;
    semicolon_seen_next = semicolon_seen;
    has_op = 1'b0;
    push_op.code = OP_PRINT;
    push_op.arg1 = c;
    push_op.arg2 = semicolon_seen ? second_arg : '0;
    if (escape_active) begin
      if (is_digit) begin
        if (semicolon_seen) begin
          second_arg_next = add_digit(second_arg, digit);
        end else begin
          first_arg_next = add_digit(first_arg, digit);
        end
      end else if (c == CH_SEMI) begin
        semicolon_seen_next = 1'b1;
      end else if (is_letter) begin
        push_op.arg1 = first_arg;
        has_op = 1'b1;
        case (c)
          CH_UP_A: push_op.code = OP_UP;
          CH_UP_B: push_op.code = OP_DOWN;
          CH_UP_C: push_op.code = OP_RIGHT;
          CH_UP_D: push_op.code = OP_LEFT;
          CH_UP_H: push_op.code = OP_HOME;
          CH_UP_J: push_op.code = OP_CLEAR;
          default: has_op = 1'b0;
        endcase
        escape_active_next = 1'b0;
        first_arg_next = '0;
        second_arg_next = '0;
        semicolon_seen_next = 1'b0;
      end
    end else begin
      case (c)
        CH_LF: begin
          has_op = 1'b1;
          push_op.code = OP_NEWLINE;
        end
        CH_TAB: begin
          has_op = 1'b1;
          push_op.code = OP_TAB;
        end
        CH_CR: begin
          has_op = 1'b1;
          push_op.code = OP_CR;
        end
        CH_BS: begin
          has_op = 1'b1;
          push_op.code = OP_BS;
        end
        CH_FF: begin
          has_op = 1'b1;
          push_op.code = OP_FF;
        end
        CH_ESC: begin
          escape_active_next = 1'b1;
          first_arg_next = '0;
          second_arg_next = '0;
          semicolon_seen_next = 1'b0;
        end
        default: begin
          if ((c >= CH_SPACE) && (c <= CH_TILDE)) begin
            has_op = 1'b1;
            push_op.code = OP_PRINT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_active <= 1'b0;
      first_arg <= '0;
      second_arg <= '0;
      semicolon_seen <= 1'b0;
    end else if (take) begin
      escape_active <= escape_active_next;
      first_arg <= first_arg_next;
      second_arg <= second_arg_next;
      semicolon_seen <= semicolon_seen_next;
    end
  end

endmodule

`default_nettype wire

[hdl/ttc_queue.sv]
// Short operation queue between the classifier and the command sequencer.
`default_nettype none

module ttc_queue import ttc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire op_t  push_op,
  input  wire logic push_valid,
  output logic      push_ready,
  output op_t       pop_op,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_op = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/ttc_back.sv]
// Command sequencer: owns the cursor, emits one screen command per cycle unless stalled.
`default_nettype none

module ttc_back import ttc_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire op_t   pop_op,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  ttc_cmd_if.source  cmd_ch
);

  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [8:0]       ROW_LIM = 9'(ROWS);
  localparam logic [8:0]       COL_LIM = 9'(COLUMNS);

  back_state_t        state, state_next;
  logic [ROW_W-1:0]   cursor_row, cursor_row_next;
  logic [COL_W-1:0]   cursor_col, cursor_col_next;
  logic [1:0]         fill_left, fill_left_next;
  logic               tab_mode, tab_mode_next;
  logic               home_mode, home_mode_next;
  logic [GLYPH_W-1:0] glyph_q, glyph_q_next;

  logic               out_valid;
  cmd_t               out_cmd;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [GLYPH_W-1:0] out_glyph;
  logic               out_last;

  logic               can_emit;
  logic               emit;
  cmd_t               e_cmd;
  logic [ROW_W-1:0]   e_row;
  logic [COL_W-1:0]   e_col;
  logic [GLYPH_W-1:0] e_glyph;
  logic               e_last;

  logic [8:0]         row_sum;
  logic [8:0]         col_sum;
  logic [ARG_W-1:0]   home_row;
  logic [ARG_W-1:0]   home_col;

  assign can_emit = !out_valid || cmd_ch.ready;
  assign row_sum = {4'b0, cursor_row} + {1'b0, pop_op.arg1};
  assign col_sum = {2'b0, cursor_col} + {1'b0, pop_op.arg1};
  assign home_row = (pop_op.arg1 == '0) ? '0 : pop_op.arg1 - 1'b1;
  assign home_col = (pop_op.arg2 == '0) ? '0 : pop_op.arg2 - 1'b1;

  always_comb begin
    state_next = state;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    fill_left_next = fill_left;
    tab_mode_next = tab_mode;
    home_mode_next = home_mode;
    glyph_q_next = glyph_q;
    pop_ready = 1'b0;
    emit = 1'b0;
    e_cmd = CMD_PLACE;
    e_row = cursor_row;
    e_col = cursor_col;
    e_glyph = '0;
    e_last = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          tab_mode_next = 1'b0;
          state_next = BK_PLACE;
          case (pop_op.code)
            OP_PRINT: begin
              glyph_q_next = pop_op.arg1[GLYPH_W-1:0];
              fill_left_next = '0;
              state_next = BK_WRITE;
            end
            OP_TAB: begin
              // fill spaces after the first one, up to the next multiple of four
              glyph_q_next = GLYPH_SPACE;
              fill_left_next = ~cursor_col[1:0];
              tab_mode_next = 1'b1;
              state_next = BK_WRITE;
            end
            OP_NEWLINE: begin
              cursor_col_next = '0;
              if (cursor_row == ROW_MAX) begin
                state_next = BK_SCROLL;
              end else begin
                cursor_row_next = cursor_row + 1'b1;
              end
            end
            OP_CR: cursor_col_next = '0;
            OP_BS: begin
              if (cursor_col != '0) begin
                cursor_col_next = cursor_col - 1'b1;
              end else if (cursor_row != '0) begin
                cursor_row_next = cursor_row - 1'b1;
                cursor_col_next = COL_MAX;
              end
            end
            OP_FF: begin
              cursor_row_next = '0;
              cursor_col_next = '0;
              home_mode_next = 1'b1;
              state_next = BK_CLEAR;
            end
            OP_CLEAR: begin
              home_mode_next = 1'b0;
              state_next = BK_CLEAR;
            end
            OP_UP: begin
              if (pop_op.arg1 > {3'b0, cursor_row}) begin
                cursor_row_next = '0;
              end else begin
                cursor_row_next = cursor_row - pop_op.arg1[ROW_W-1:0];
              end
            end
            OP_DOWN: begin
              cursor_row_next = (row_sum >= ROW_LIM) ? ROW_MAX : row_sum[ROW_W-1:0];
            end
            OP_RIGHT: begin
              cursor_col_next = (col_sum >= COL_LIM) ? COL_MAX : col_sum[COL_W-1:0];
            end
            OP_LEFT: begin
              if (pop_op.arg1 > {1'b0, cursor_col}) begin
                cursor_col_next = '0;
              end else begin
                cursor_col_next = cursor_col - pop_op.arg1[COL_W-1:0];
              end
            end
            OP_HOME: begin
              cursor_row_next = ({1'b0, home_row} >= ROW_LIM) ? ROW_MAX
                                                              : home_row[ROW_W-1:0];
              cursor_col_next = ({1'b0, home_col} >= COL_LIM) ? COL_MAX
                                                              : home_col[COL_W-1:0];
            end
            default: state_next = BK_IDLE;
          endcase
        end
      end
      BK_WRITE: begin
        if (can_emit) begin
          emit = 1'b1;
          e_cmd = CMD_WRITE;
          e_glyph = glyph_q;
          state_next = BK_PLACE;
          if (cursor_col == COL_MAX) begin
            cursor_col_next = '0;
            if (cursor_row == ROW_MAX) begin
              state_next = BK_SCROLL;
            end else begin
              cursor_row_next = cursor_row + 1'b1;
            end
          end else begin
            cursor_col_next = cursor_col + 1'b1;
          end
        end
      end
      BK_SCROLL: begin
        if (can_emit) begin
          emit = 1'b1;
          e_cmd = CMD_SCROLL;
          e_row = '0;
          e_col = '0;
          state_next = BK_PLACE;
        end
      end
      BK_PLACE: begin
        if (can_emit) begin
          emit = 1'b1;
          if (tab_mode) begin
            if (fill_left != '0) begin
              fill_left_next = fill_left - 1'b1;
              state_next = BK_WRITE;
            end else begin
              state_next = BK_TAIL;
            end
          end else begin
            e_last = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      BK_TAIL: begin
        if (can_emit) begin
          emit = 1'b1;
          e_last = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        if (can_emit) begin
          emit = 1'b1;
          e_cmd = CMD_CLEAR;
          e_row = '0;
          e_col = '0;
          if (home_mode) begin
            state_next = BK_PLACE;
          end else begin
            e_last = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cursor_row <= '0;
      cursor_col <= '0;
      fill_left <= '0;
      tab_mode <= 1'b0;
      home_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      fill_left <= fill_left_next;
      tab_mode <= tab_mode_next;
      home_mode <= home_mode_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (cmd_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    glyph_q <= glyph_q_next;
    if (emit) begin
      out_cmd <= e_cmd;
      out_row <= e_row;
      out_col <= e_col;
      out_glyph <= e_glyph;
      out_last <= e_last;
    end
  end

  assign cmd_ch.valid = out_valid;
  assign cmd_ch.command = out_cmd;
  assign cmd_ch.row = out_row;
  assign cmd_ch.column = out_col;
  assign cmd_ch.glyph = out_glyph;
  assign cmd_ch.last = out_last;

endmodule

`default_nettype wire

[hdl/text_terminal_cursor_engine.sv]
// Top level of the text terminal cursor engine: classifier, queue and sequencer.
//
//   channel   modport  payload                                 transfer when
//   byte_ch   sink     char_byte[7:0]                          valid && ready
//   cmd_ch    source   command, row, column, glyph, last       valid && ready
//
// The classifier is combinational: a byte enters the queue at the edge it transfers.
// The sequencer takes an operation only when idle, then emits its commands: a write, a
// bottom-row scroll and a placement for a printable; for a tab up to four writes, four
// placements, one scroll and a closing placement. One command per cycle sets the rate.
// Synchronous reset homes the cursor, drops any escape sequence and empties the queue.
// A stalled cmd_ch holds the sequencer; the four-entry queue takes bytes until full.
`default_nettype none

module text_terminal_cursor_engine import ttc_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic clk,
  input  wire logic rst,
  ttc_byte_if.sink  byte_ch,
  ttc_cmd_if.source cmd_ch
);

  op_t  push_op;
  logic push_valid;
  logic push_ready;
  op_t  pop_op;
  logic pop_valid;
  logic pop_ready;

  ttc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ttc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  ttc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_op    (pop_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cmd_ch    (cmd_ch)
  );

  a_place_on_screen: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && (cmd_ch.command == CMD_PLACE || cmd_ch.command == CMD_WRITE) |->
      (32'(cmd_ch.row) < ROWS) && (32'(cmd_ch.column) < COLUMNS))
    else $error("cursor position outside the screen");

  a_bare_fields: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && (cmd_ch.command == CMD_SCROLL || cmd_ch.command == CMD_CLEAR) |->
      (cmd_ch.row == '0) && (cmd_ch.column == '0) && (cmd_ch.glyph == '0))
    else $error("scroll or clear carries nonzero fields");

  a_write_printable: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && (cmd_ch.command == CMD_WRITE) |->
      (cmd_ch.glyph >= GLYPH_SPACE) && !cmd_ch.last)
    else $error("write command with bad glyph or marked last");

endmodule

`default_nettype wire
